FILE: rtl/bswc_pkg.sv
package bswc_pkg;

  localparam int PIX_W  = 16;
  localparam int RUN_W  = 7;
  localparam int CNT_W  = 21;
  localparam int SIDE_W = 11;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic [SIDE_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [RUN_W-1:0]  WINDOW_RST = 7'd3;
  localparam logic [PIX_W-1:0]  THRESH_RST = 16'd19661;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [SIDE_W-1:0] width_in_use;
    logic [RUN_W-1:0]  window_size;
    logic [PIX_W-1:0]  threshold;
  } cfg_t;

endpackage

FILE: rtl/bswc_regs.sv
module bswc_regs import bswc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_in_use <= WIDTH_RST;
      cfg_r.window_size  <= WINDOW_RST;
      cfg_r.threshold    <= THRESH_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_WIDTH:  cfg_r.width_in_use <= pwdata[SIDE_W-1:0];
        REG_WINDOW: cfg_r.window_size  <= pwdata[RUN_W-1:0];
        REG_THRESH: cfg_r.threshold    <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = DATA_W'(cfg_r.width_in_use);
      REG_WINDOW: prdata = DATA_W'(cfg_r.window_size);
      REG_THRESH: prdata = DATA_W'(cfg_r.threshold);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/bswc_colmem.sv
module bswc_colmem import bswc_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [RUN_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [RUN_W-1:0] wr_data
);

  logic [RUN_W-1:0] mem [DEPTH];
  logic [RUN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/bright_square_window_count_core.sv
// Bright square window counter.
// Input channel (in_valid / in_stall / in_pixel): one pixel per beat, raster
// order, frame of width_in_use x width_in_use pixels. A pixel is bright if it
// is at or above threshold.
// Result channel (out_valid / out_stall / out_window_count): one beat per
// frame, the number of window_size x window_size all-bright windows.
// Config (APB, pready tied high): 0x0 width_in_use, 0x4 window_size,
// 0x8 threshold. Write only while the block is idle.
// Throughput: one pixel per cycle while in_stall is low. Pixel stage reads
// the column run store; run stage updates it from the registered read data;
// a same-column read right behind a write is forwarded.
// The result register loads when the run stage passes on the last pixel.
// Reset: config to defaults, frame position and count cleared. The column
// store is not cleared; row 0 ignores what it reads from it.
// Stall: a pending result holds while out_stall is high. Pixels keep flowing
// until the next frame's result is ready; then in_stall rises until the
// pending result is taken.
module bright_square_window_count_core import bswc_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CNT_W-1:0]  out_window_count,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W = $clog2(MAX_WIDTH);

  cfg_t cfg;

  bswc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [RUN_W-1:0] k_eff;
  logic [IDX_W-1:0] last_idx;

  assign k_eff = (cfg.window_size == '0) ? RUN_W'(1) : cfg.window_size;

  always_comb begin
    if (cfg.width_in_use == '0) begin
      last_idx = '0;
    end else if (32'(cfg.width_in_use) > 32'(MAX_WIDTH)) begin
      last_idx = IDX_W'(MAX_WIDTH - 1);
    end else begin
      last_idx = IDX_W'(cfg.width_in_use - SIDE_W'(1));
    end
  end

  // pixel stage
  logic [RUN_W-1:0] row_run_r, row_run_nxt;
  logic [RUN_W:0]   rr_inc;
  logic [IDX_W-1:0] col_r, row_r;
  logic             col_end, row_end, in_acc;

  assign in_acc  = in_valid && !in_stall;
  assign col_end = col_r >= last_idx;
  assign row_end = row_r >= last_idx;
  assign rr_inc  = {1'b0, row_run_r} + (RUN_W+1)'(1);

  always_comb begin
    if (in_pixel >= cfg.threshold) begin
      row_run_nxt = (rr_inc >= {1'b0, k_eff}) ? k_eff : rr_inc[RUN_W-1:0];
    end else begin
      row_run_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_run_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
    end else if (in_acc) begin
      if (col_end) begin
        col_r     <= '0;
        row_run_r <= '0;
        row_r     <= row_end ? '0 : row_r + IDX_W'(1);
      end else begin
        col_r     <= col_r + IDX_W'(1);
        row_run_r <= row_run_nxt;
      end
    end
  end

  // run stage
  logic             s1_valid_r, s1_first_row_r, s1_full_r, s1_last_r;
  logic [IDX_W-1:0] s1_col_r;
  logic             fwd_r;
  logic [RUN_W-1:0] fwd_data_r;
  logic [RUN_W-1:0] rd_data, prev_vert, vert;
  logic [RUN_W:0]   v_inc;
  logic             s1_hold, s1_fire, hit;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_count_r;

  assign s1_hold  = s1_valid_r && s1_last_r && out_valid_r && out_stall;
  assign s1_fire  = s1_valid_r && !s1_hold;
  assign in_stall = s1_hold;

  assign prev_vert = s1_first_row_r ? '0 : (fwd_r ? fwd_data_r : rd_data);
  assign v_inc     = {1'b0, prev_vert} + (RUN_W+1)'(1);

  always_comb begin
    if (s1_full_r) begin
      vert = (v_inc >= {1'b0, k_eff}) ? k_eff : v_inc[RUN_W-1:0];
    end else begin
      vert = '0;
    end
  end

  assign hit       = vert >= k_eff;
  assign count_nxt = (hit && count_r != CNT_MAX) ? count_r + CNT_W'(1) : count_r;

  bswc_colmem #(
    .DEPTH (MAX_WIDTH),
    .AW    (IDX_W)
  ) u_colmem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (vert)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r       <= col_r;
      s1_first_row_r <= row_r == '0;
      s1_full_r      <= row_run_nxt >= k_eff;
      s1_last_r      <= col_end && row_end;
      fwd_r          <= s1_fire && (s1_col_r == col_r);
      fwd_data_r     <= vert;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (s1_fire) begin
      count_r <= s1_last_r ? '0 : count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_count_r <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_count = out_count_r;

endmodule

FILE: rtl/bswc_checker.sv
module bswc_checker import bswc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CNT_W-1:0] out_window_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_window_count))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no result pending");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding pixel");

endmodule

bind bright_square_window_count_core bswc_checker u_bswc_checker (.*);
